// ----- sv/sil_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and codes for the sorted integer list.
// ----------------------------------------------------------------------------
package sil_pkg;

    localparam int RES_W = 9;

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2
    } status_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [RES_W-1:0] rem_pos;
    } cell_ctrl_t;

endpackage

// ----- sv/sil_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_cell
// One slot of the list: holds an entry and its valid bit, compares the entry
// against the request value and shifts up or down with its neighbors.
// ----------------------------------------------------------------------------
module sil_cell
    import sil_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_ctrl_t             ctrl,
    input  logic [VALUE_WIDTH-1:0] v,
    input  logic                   prev_t,
    input  logic                   prev_valid,
    input  logic [VALUE_WIDTH-1:0] prev_entry,
    input  logic                   next_valid,
    input  logic [VALUE_WIDTH-1:0] next_entry,
    output logic                   t,
    output logic                   valid,
    output logic [VALUE_WIDTH-1:0] entry
);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   at_or_above_pos;

    assign t               = valid_reg && (entry_reg <= v);
    assign at_or_above_pos = RES_W'(INDEX) >= ctrl.rem_pos;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.ins)
        begin
            valid_next = prev_valid;
            if (!t)
            begin
                // first cell past the not-greater prefix takes the value
                entry_next = prev_t ? v : prev_entry;
            end
        end
        else if (ctrl.rem && at_or_above_pos)
        begin
            entry_next = next_entry;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            valid_reg <= valid_next;
        end
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// ----- sv/sil_pos_enc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pos_enc
// Turns the prefix mask of entries not greater than the value into the
// insertion position (length of the prefix).
// ----------------------------------------------------------------------------
module sil_pos_enc
    import sil_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic [DEPTH-1:0]               therm,
    output logic [$clog2(DEPTH+1)-1:0]     pos
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0] edge_hit;

    // mark the last set cell of the prefix
    always_comb
    begin
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            edge_hit[i] = therm[i] && !therm[i+1];
        end
        edge_hit[DEPTH-1] = therm[DEPTH-1];
    end

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            pos = pos | (edge_hit[i] ? CW'(i + 1) : CW'(0));
        end
    end

endmodule

// ----- sv/sorted_integer_list_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_integer_list_top
// Fixed-capacity list of unsigned integers kept in non-decreasing order.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge where start is high and busy is low.
//   op selects find, insert or remove; value is used by find and insert,
//   position by remove. Every request returns exactly one result.
//   The result shows on found_position, entry_count and status for one
//   cycle with done high, in the cycle after the request is taken.
//   busy stays low: a new request can be taken every cycle, since each
//   cell compares combinationally and shifts on the edge that takes it.
//   Throughput is 1 request per cycle; the critical path
//   is the compare in each cell plus the position encoder.
//   Insert on a full list reports status full; remove at a position not
//   below the count reports a bad position; neither changes the list.
//   Reset clears every cell and the count; the list starts empty.
//   The receiver cannot hold results off; it must sample on done.
// ----------------------------------------------------------------------------
module sorted_integer_list_top
    import sil_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       op,
    input  logic [15:0]      value,
    input  logic [7:0]       position,
    output logic             done,
    output logic [RES_W-1:0] found_position,
    output logic [RES_W-1:0] entry_count,
    output logic [1:0]       status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                   accept;
    logic [31:0]            value_ext;
    logic [VALUE_WIDTH-1:0] v;
    logic [DEPTH-1:0]       t_vec;
    logic [DEPTH-1:0]       valid_vec;
    logic [VALUE_WIDTH-1:0] entry_vec [DEPTH];
    logic [CW-1:0]          ins_pos;
    logic                   full;
    logic                   pos_ok;
    cell_ctrl_t             ctrl;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   done_reg;
    logic [RES_W-1:0]       found_reg;
    logic [RES_W-1:0]       found_next;
    status_t                status_reg;
    status_t                status_next;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign value_ext = {16'b0, value};
    assign v         = value_ext[VALUE_WIDTH-1:0];

    assign full   = count_reg == CW'(DEPTH);
    assign pos_ok = {1'b0, position} < RES_W'(count_reg);

    always_comb
    begin
        ctrl.ins     = accept && (op == OP_INSERT) && !full;
        ctrl.rem     = accept && (op == OP_REMOVE) && pos_ok;
        ctrl.rem_pos = {1'b0, position};
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                   p_t;
            logic                   p_valid;
            logic [VALUE_WIDTH-1:0] p_entry;
            logic                   n_valid;
            logic [VALUE_WIDTH-1:0] n_entry;

            if (gi == 0)
            begin : g_head
                // the head sees an always-true neighbor below it
                assign p_t     = 1'b1;
                assign p_valid = 1'b1;
                assign p_entry = '0;
            end
            else
            begin : g_body
                assign p_t     = t_vec[gi-1];
                assign p_valid = valid_vec[gi-1];
                assign p_entry = entry_vec[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign n_valid = 1'b0;
                assign n_entry = '0;
            end
            else
            begin : g_mid
                assign n_valid = valid_vec[gi+1];
                assign n_entry = entry_vec[gi+1];
            end

            sil_cell #(
                .INDEX       (gi),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .v          (v),
                .prev_t     (p_t),
                .prev_valid (p_valid),
                .prev_entry (p_entry),
                .next_valid (n_valid),
                .next_entry (n_entry),
                .t          (t_vec[gi]),
                .valid      (valid_vec[gi]),
                .entry      (entry_vec[gi])
            );
        end
    endgenerate

    sil_pos_enc #(
        .DEPTH (DEPTH)
    ) u_pos_enc (
        .therm (t_vec),
        .pos   (ins_pos)
    );

    always_comb
    begin
        count_next  = count_reg;
        found_next  = RES_W'(ins_pos);
        status_next = ST_OK;
        if (accept)
        begin
            if (op == OP_REMOVE)
            begin
                found_next = {1'b0, position};
                if (pos_ok)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = ST_BAD_POS;
                end
            end
            else if (op == OP_INSERT)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign done           = done_reg;
    assign found_position = found_reg;
    assign entry_count    = RES_W'(count_reg);
    assign status         = status_reg;

    // the number of set valid bits matches the entry count
    a_valid_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("valid bits disagree with entry count");

    a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_INSERT && !full) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full reported on a list with room");

    a_remove_pos : assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_BAD_POS) |-> (found_position >= RES_W'(count_reg)))
        else $error("bad position reported for a valid position");

endmodule
